### rtl/rrtq_pkg.sv
package rrtq_pkg;

	// Default table depth of the task queue.
	localparam int MAX_TASKS_DEF = 16;

	// Request actions.
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_SWITCH = 2'd1;
	localparam logic [1:0] ACT_SLEEP  = 2'd2;
	localparam logic [1:0] ACT_WAKE   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SINGLE    = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_INVALID   = 3'd3;
	localparam logic [2:0] ST_RUNNING   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	// Time slices per priority.
	localparam logic [6:0] QUANT_HIGH = 7'd80;
	localparam logic [6:0] QUANT_MID  = 7'd50;
	localparam logic [6:0] QUANT_LOW  = 7'd20;
	localparam logic [6:0] QUANT_NONE = 7'd0;

	// Highest ID value; it is never handed out.
	localparam logic [15:0] ID_LIMIT = 16'hFFFF;

	// One entry of the task table.
	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  prio;
		logic        run;
		logic [63:0] addr;
	} task_ent_t;

	// Task zero as it stands after reset.
	localparam task_ent_t RESET_ENT = '{id: 16'd0, prio: 2'd2, run: 1'b1, addr: 64'd0};

	// Map a priority to its time slice.
	function automatic logic [6:0] quantum_of(input logic [1:0] prio);
		logic [6:0] q;
		case (prio)
			2'd2: q = QUANT_HIGH;
			2'd1: q = QUANT_MID;
			2'd0: q = QUANT_LOW;
			default: q = QUANT_NONE;
		endcase
		return q;
	endfunction

endpackage

### rtl/rrtq_table.sv
module rrtq_table #(
	parameter int MAX_TASKS = rrtq_pkg::MAX_TASKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_TASKS)-1:0] rd_addr,
	output rrtq_pkg::task_ent_t          rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_TASKS)-1:0] wr_addr,
	input  rrtq_pkg::task_ent_t          wr_data
);
	import rrtq_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);

	task_ent_t mem [MAX_TASKS];
	task_ent_t rd_q;
	logic      init_q;
	logic      rd_init_s1;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Slot zero reads as the reset task until it is first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b1;
			rd_init_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_init_s1 <= init_q && (rd_addr == IW'(0));
			end
			if (wr_en && (wr_addr == IW'(0))) begin
				init_q <= 1'b0;
			end
		end
	end

	assign rd_data = rd_init_s1 ? RESET_ENT : rd_q;

endmodule

### rtl/rrtq_seq.sv
module rrtq_seq #(
	parameter int MAX_TASKS = rrtq_pkg::MAX_TASKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [15:0]                  task_id,
	input  logic [1:0]                   priority_req,
	input  logic                         start_running,
	input  logic [63:0]                  entry_address,
	input  logic                         sleep_current,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [15:0]                  assigned_id,
	output logic [15:0]                  current_id,
	output logic [63:0]                  current_address,
	output logic [6:0]                   quantum,
	output logic                         rd_en,
	output logic [$clog2(MAX_TASKS)-1:0] rd_addr,
	input  rrtq_pkg::task_ent_t          rd_data,
	output logic                         wr_en,
	output logic [$clog2(MAX_TASKS)-1:0] wr_addr,
	output rrtq_pkg::task_ent_t          wr_data
);
	import rrtq_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_TASKS);
	localparam logic [CW:0]   MAX_W  = (CW + 1)'(MAX_TASKS);
	localparam logic [IW-1:0] LAST_S = IW'(MAX_TASKS - 1);

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;
	localparam logic [3:0] S_SWHEAD = 4'd2;
	localparam logic [3:0] S_SWTAIL = 4'd3;
	localparam logic [3:0] S_SLCHK  = 4'd4;
	localparam logic [3:0] S_SCAN   = 4'd5;
	localparam logic [3:0] S_QRD    = 4'd6;
	localparam logic [3:0] S_QHEAD  = 4'd7;
	localparam logic [3:0] S_QSCAN  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]    state_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [15:0]   next_id_q;
	logic [CW-1:0] pos_q;
	logic          rd_v_s1;
	logic [IW-1:0] slot_s1;
	logic          mark_q;
	logic          out_valid_q;

	logic [1:0]    act_q;
	logic [15:0]   id_q;
	logic [1:0]    prio_q;
	logic          run_q;
	logic [63:0]   addr_q;
	logic          sleep_q;
	logic [2:0]    status_q;
	logic [15:0]   assigned_q;
	task_ent_t     ent_q;
	logic [15:0]   cur_id_q;
	logic [63:0]   cur_addr_q;
	logic [1:0]    qprio_q;
	logic [2:0]    status_o_q;
	logic [15:0]   assigned_o_q;
	logic [15:0]   cur_id_o_q;
	logic [63:0]   cur_addr_o_q;
	logic [6:0]    quantum_o_q;

	logic          scanning;
	logic          scan_hit;
	logic          scan_issue;
	logic          scan_miss;
	logic [CW-1:0] slot_pos;
	logic [CW:0]   slot_sum;
	logic [IW-1:0] slot_sel;
	logic [IW-1:0] head_inc;
	logic          is_full;
	logic          is_single;
	logic          head_match;
	logic          out_load;
	task_ent_t     ent_mark;
	task_ent_t     ent_new;
	task_ent_t     ent_upd;

	// Shared slot adder: queue position to table slot, wrapping at the depth.
	assign slot_pos = scanning ? pos_q : count_q;
	always_comb begin
		slot_sum = {{(CW + 1 - IW){1'b0}}, head_q} + {1'b0, slot_pos};
		if (slot_sum >= MAX_W) begin
			slot_sum = slot_sum - MAX_W;
		end
		slot_sel = slot_sum[IW-1:0];
	end

	assign head_inc = (head_q == LAST_S) ? IW'(0) : head_q + IW'(1);

	// Scan unit: one table read issued per cycle until a hit or the queue end, each checked in the cycle after.
	assign scanning   = (state_q == S_SCAN) || (state_q == S_QSCAN);
	assign scan_hit   = rd_v_s1 && ((state_q == S_QSCAN) ? rd_data.run : (rd_data.id == id_q));
	assign scan_issue = scanning && (pos_q < count_q) && !scan_hit;
	assign scan_miss  = !rd_v_s1 && (pos_q >= count_q);

	assign is_full    = (count_q == MAX_C) || (next_id_q == ID_LIMIT);
	assign is_single  = (count_q <= CW'(1));
	assign head_match = (rd_data.id == id_q);
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Candidate entries for the write port.
	always_comb begin
		ent_new = '{id: next_id_q, prio: prio_q, run: run_q, addr: addr_q};
		ent_mark = rd_data;
		ent_mark.run = rd_data.run && !mark_q;
		ent_upd = rd_data;
		ent_upd.run = (act_q == ACT_WAKE);
	end

	// Table port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = ent_q;
		case (state_q)
			S_DISP: begin
				if (act_q == ACT_ADD) begin
					wr_en   = !is_full;
					wr_addr = slot_sel;
					wr_data = ent_new;
				end else if (act_q == ACT_SLEEP) begin
					rd_en = 1'b1;
				end else if (act_q == ACT_SWITCH) begin
					rd_en = !is_single;
				end
			end
			S_SWHEAD: begin
				wr_en   = mark_q;
				wr_data = ent_mark;
			end
			S_SWTAIL: begin
				wr_en   = 1'b1;
				wr_addr = slot_sel;
			end
			S_SLCHK: begin
				rd_en = head_match && !is_single;
			end
			S_SCAN: begin
				rd_en   = scan_issue;
				rd_addr = slot_sel;
				wr_en   = scan_hit && !((act_q == ACT_WAKE) && rd_data.run);
				wr_addr = slot_s1;
				wr_data = ent_upd;
			end
			S_QRD: begin
				rd_en = 1'b1;
			end
			S_QSCAN: begin
				rd_en   = scan_issue;
				rd_addr = slot_sel;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Sequencer and queue bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= CW'(1);
			next_id_q   <= 16'd1;
			pos_q       <= '0;
			rd_v_s1     <= 1'b0;
			mark_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (scanning) begin
				if (scan_issue) begin
					pos_q <= pos_q + CW'(1);
				end
				rd_v_s1 <= scan_issue;
			end else begin
				rd_v_s1 <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (act_q)
						ACT_ADD: begin
							if (!is_full) begin
								count_q   <= count_q + CW'(1);
								next_id_q <= next_id_q + 16'd1;
							end
							state_q <= S_QRD;
						end
						ACT_SWITCH: begin
							mark_q  <= sleep_q;
							state_q <= is_single ? S_QRD : S_SWHEAD;
						end
						ACT_SLEEP: begin
							state_q <= S_SLCHK;
						end
						default: begin
							pos_q   <= '0;
							state_q <= (id_q > next_id_q) ? S_QRD : S_SCAN;
						end
					endcase
				end
				S_SWHEAD: begin
					if (count_q == MAX_C) begin
						head_q  <= head_inc;
						state_q <= S_QRD;
					end else begin
						state_q <= S_SWTAIL;
					end
				end
				S_SWTAIL: begin
					head_q  <= head_inc;
					state_q <= S_QRD;
				end
				S_SLCHK: begin
					if (head_match) begin
						mark_q  <= 1'b1;
						state_q <= is_single ? S_QRD : S_SWHEAD;
					end else begin
						pos_q   <= CW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_hit || scan_miss) begin
						state_q <= S_QRD;
					end
				end
				S_QRD: begin
					state_q <= S_QHEAD;
				end
				S_QHEAD: begin
					pos_q   <= CW'(1);
					state_q <= S_QSCAN;
				end
				S_QSCAN: begin
					if (scan_hit || scan_miss) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, working values and the result register.
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			slot_s1 <= slot_sel;
		end
		case (state_q)
			S_IDLE: begin
				act_q      <= action;
				id_q       <= task_id;
				prio_q     <= priority_req;
				run_q      <= start_running;
				addr_q     <= entry_address;
				sleep_q    <= sleep_current;
				status_q   <= ST_OK;
				assigned_q <= 16'd0;
			end
			S_DISP: begin
				if (act_q == ACT_ADD) begin
					if (is_full) begin
						status_q <= ST_FULL;
					end else begin
						assigned_q <= next_id_q;
					end
				end else if ((act_q == ACT_SWITCH) && is_single) begin
					status_q <= ST_SINGLE;
				end else if ((act_q == ACT_WAKE) && (id_q > next_id_q)) begin
					status_q <= ST_INVALID;
				end
			end
			S_SWHEAD: begin
				ent_q <= ent_mark;
			end
			S_SLCHK: begin
				if (head_match && is_single) begin
					status_q <= ST_SINGLE;
				end
			end
			S_SCAN: begin
				if (scan_hit && (act_q == ACT_WAKE) && rd_data.run) begin
					status_q <= ST_RUNNING;
				end else if (!scan_hit && scan_miss) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_QHEAD: begin
				cur_id_q   <= rd_data.id;
				cur_addr_q <= rd_data.addr;
				qprio_q    <= rd_data.prio;
			end
			S_QSCAN: begin
				if (scan_hit) begin
					qprio_q <= rd_data.prio;
				end
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
		if (out_load) begin
			status_o_q   <= status_q;
			assigned_o_q <= assigned_q;
			cur_id_o_q   <= cur_id_q;
			cur_addr_o_q <= cur_addr_q;
			quantum_o_q  <= quantum_of(qprio_q);
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_o_q;
	assign assigned_id     = assigned_o_q;
	assign current_id      = cur_id_o_q;
	assign current_address = cur_addr_o_q;
	assign quantum         = quantum_o_q;

endmodule

### rtl/round_robin_task_queue_top.sv
// Channel   Handshake              Payload
// request   in_valid / in_ready    action, task_id, priority_req, start_running,
//                                  entry_address, sleep_current
// result    out_valid / out_ready  status, assigned_id, current_id,
//                                  current_address, quantum
//
// One request at a time. All table traffic goes through one read and one write port.
// Each request passes dispatch, then a rotation, the sleep head check or a search as needed,
// then the head read and the scan for the next running task, and waits to load its result.
// Reset leaves task zero alone; slot zero reads as that task until written, so no clearing.
// A result waits in its own register; the next request is taken while it is stalled.
module round_robin_task_queue_top #(
	parameter int MAX_TASKS = rrtq_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] task_id,
	input  logic [1:0]  priority_req,
	input  logic        start_running,
	input  logic [63:0] entry_address,
	input  logic        sleep_current,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] assigned_id,
	output logic [15:0] current_id,
	output logic [63:0] current_address,
	output logic [6:0]  quantum
);
	import rrtq_pkg::*;

	localparam int IW = $clog2(MAX_TASKS);

	logic          rd_en;
	logic [IW-1:0] rd_addr;
	task_ent_t     rd_data;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	task_ent_t     wr_data;

	// Sequencer with the shared slot adder and scan compare.
	rrtq_seq #(
		.MAX_TASKS(MAX_TASKS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.task_id        (task_id),
		.priority_req   (priority_req),
		.start_running  (start_running),
		.entry_address  (entry_address),
		.sleep_current  (sleep_current),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.assigned_id    (assigned_id),
		.current_id     (current_id),
		.current_address(current_address),
		.quantum        (quantum),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data)
	);

	// Task table.
	rrtq_table #(
		.MAX_TASKS(MAX_TASKS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

### rtl/rrtq_checker.sv
module rrtq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] assigned_id,
	input logic [6:0]  quantum
);
	import rrtq_pkg::*;

	// An accepted request keeps in_ready low in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
	else $error("request accepted on back-to-back cycles");

	// A stalled result holds its status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
	else $error("stalled result changed");

	// Only a successful add reports an ID.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (assigned_id == 16'd0))
	else $error("ID reported without a successful add");

	// Status and quantum stay within their codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status <= ST_FULL) && ((quantum == QUANT_HIGH) ||
		(quantum == QUANT_MID) || (quantum == QUANT_LOW) || (quantum == QUANT_NONE))))
	else $error("result code out of range");

endmodule

bind round_robin_task_queue_top rrtq_checker u_rrtq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.assigned_id(assigned_id),
	.quantum    (quantum)
);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rrtq_pkg::*;

	localparam int MAX_TASKS = MAX_TASKS_DEF;

	// One expected scheduler result.
	typedef struct {
		logic [2:0]  status;
		logic [15:0] assigned;
		logic [15:0] cur_id;
		logic [63:0] cur_addr;
		logic [6:0]  quantum;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = ACT_SWITCH;
	logic [15:0] task_id = '0;
	logic [1:0]  priority_req = '0;
	logic        start_running = 1'b0;
	logic [63:0] entry_address = '0;
	logic        sleep_current = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [15:0] assigned_id;
	logic [15:0] current_id;
	logic [63:0] current_address;
	logic [6:0]  quantum;

	// Mirror of the task queue, advanced once per accepted request.
	logic [15:0] tq_id [MAX_TASKS];
	logic [1:0]  tq_prio [MAX_TASKS];
	logic        tq_run [MAX_TASKS];
	logic [63:0] tq_addr [MAX_TASKS];
	int unsigned tq_head;
	int unsigned tq_count;
	int unsigned tq_next_id;

	sched_result_t pending_results[$];
	int unsigned   mismatch_count = 0;
	int unsigned   result_count = 0;
	int            sender_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            hold_left = 0;

	round_robin_task_queue_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.task_id(task_id),
		.priority_req(priority_req),
		.start_running(start_running),
		.entry_address(entry_address),
		.sleep_current(sleep_current),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.assigned_id(assigned_id),
		.current_id(current_id),
		.current_address(current_address),
		.quantum(quantum)
	);

	always #5 clk = ~clk;

	// Queue contents after reset: only task zero, running at the top priority.
	function automatic void reset_queue_model();
		for (int i = 0; i < MAX_TASKS; i++) begin
			tq_id[i] = '0;
			tq_prio[i] = '0;
			tq_run[i] = 1'b0;
			tq_addr[i] = '0;
		end
		tq_prio[0] = 2'd2;
		tq_run[0] = 1'b1;
		tq_head = 0;
		tq_count = 1;
		tq_next_id = 1;
	endfunction

	function automatic int unsigned slot_at(int unsigned pos);
		return (tq_head + pos) % MAX_TASKS;
	endfunction

	// Queue position of a task ID, or the task count when it is absent.
	function automatic int unsigned locate_task(logic [15:0] id);
		for (int unsigned p = 0; p < tq_count; p++) begin
			if (tq_id[slot_at(p)] == id)
				return p;
		end
		return tq_count;
	endfunction

	// Move the head to the tail; a full table already has it there.
	function automatic logic [2:0] rotate_head(logic mark_sleep);
		int unsigned h;
		int unsigned t;
		if (tq_count <= 1)
			return ST_SINGLE;
		h = slot_at(0);
		if (mark_sleep)
			tq_run[h] = 1'b0;
		if (tq_count < MAX_TASKS) begin
			t = slot_at(tq_count);
			tq_id[t] = tq_id[h];
			tq_prio[t] = tq_prio[h];
			tq_run[t] = tq_run[h];
			tq_addr[t] = tq_addr[h];
		end
		tq_head = (tq_head + 1) % MAX_TASKS;
		return ST_OK;
	endfunction

	// Time slice of the first running task behind the head, else of the head.
	function automatic logic [6:0] expected_slice();
		logic [1:0] p;
		p = tq_prio[slot_at(0)];
		for (int unsigned i = 1; i < tq_count; i++) begin
			if (tq_run[slot_at(i)]) begin
				p = tq_prio[slot_at(i)];
				break;
			end
		end
		case (p)
			2'd2: return QUANT_HIGH;
			2'd1: return QUANT_MID;
			2'd0: return QUANT_LOW;
			default: return QUANT_NONE;
		endcase
	endfunction

	// Apply one request to the mirror and return the result it must produce.
	function automatic sched_result_t apply_request(logic [1:0] act, logic [15:0] id,
			logic [1:0] prio, logic run, logic [63:0] addr, logic sleep_cur);
		sched_result_t r;
		int unsigned pos;
		int unsigned s;
		r.status = ST_OK;
		r.assigned = '0;
		case (act)
			ACT_ADD: begin
				if (tq_count >= MAX_TASKS || tq_next_id >= ID_LIMIT) begin
					r.status = ST_FULL;
				end else begin
					s = slot_at(tq_count);
					tq_id[s] = tq_next_id[15:0];
					tq_prio[s] = prio;
					tq_run[s] = run;
					tq_addr[s] = addr;
					r.assigned = tq_next_id[15:0];
					tq_count++;
					tq_next_id++;
				end
			end
			ACT_SWITCH: begin
				r.status = rotate_head(sleep_cur);
			end
			ACT_SLEEP: begin
				if (tq_id[slot_at(0)] == id) begin
					r.status = rotate_head(1'b1);
				end else begin
					pos = locate_task(id);
					if (pos >= tq_count)
						r.status = ST_NOT_FOUND;
					else
						tq_run[slot_at(pos)] = 1'b0;
				end
			end
			default: begin
				if (id > tq_next_id) begin
					r.status = ST_INVALID;
				end else begin
					pos = locate_task(id);
					if (pos >= tq_count)
						r.status = ST_NOT_FOUND;
					else if (tq_run[slot_at(pos)])
						r.status = ST_RUNNING;
					else
						tq_run[slot_at(pos)] = 1'b1;
				end
			end
		endcase
		r.cur_id = tq_id[slot_at(0)];
		r.cur_addr = tq_addr[slot_at(0)];
		r.quantum = expected_slice();
		return r;
	endfunction

	function automatic logic [63:0] rand_addr();
		return {$urandom, $urandom};
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("result %0d: %s got %0h, expected %0h", result_count, field, got, want);
		mismatch_count++;
	endtask

	// Offer one request, idling first at random, and record its expected result.
	task automatic send_request(logic [1:0] act, logic [15:0] id, logic [1:0] prio,
			logic run, logic [63:0] addr, logic sleep_cur);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		task_id <= id;
		priority_req <= prio;
		start_running <= run;
		entry_address <= addr;
		sleep_current <= sleep_cur;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.insert(pending_results.size(),
			apply_request(act, id, prio, run, addr, sleep_cur));
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Random request: sleep and wakeup dominate, adds are rare so the table fills slowly.
	task automatic send_random_request();
		logic [1:0]  act;
		logic [15:0] id;
		int          w;
		w = $urandom_range(99);
		if (w < 2)
			act = ACT_ADD;
		else if (w < 32)
			act = ACT_SWITCH;
		else if (w < 66)
			act = ACT_SLEEP;
		else
			act = ACT_WAKE;
		w = $urandom_range(99);
		if (w < 70)
			id = 16'($urandom_range(tq_next_id + 1));
		else if (w < 85)
			id = 16'($urandom_range(20));
		else
			id = 16'($urandom_range(16'hFFFF));
		send_request(act, id, 2'($urandom_range(3)), 1'($urandom_range(1)), rand_addr(),
			1'($urandom_range(1)));
	endtask

	// Extremes of the fields and each corner of the four actions.
	task automatic test_directed_cases();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		send_request(ACT_SWITCH, 16'd0, 2'd0, 1'b0, '0, 1'b1);
		send_request(ACT_SLEEP, 16'd0, 2'd3, 1'b1, rand_addr(), 1'b0);
		send_request(ACT_SLEEP, 16'd9, 2'd1, 1'b0, rand_addr(), 1'b1);
		send_request(ACT_WAKE, 16'd0, 2'd2, 1'b1, rand_addr(), 1'b0);
		send_request(ACT_WAKE, 16'd1, 2'd0, 1'b0, rand_addr(), 1'b1);
		send_request(ACT_WAKE, 16'hFFFF, 2'd3, 1'b1, '1, 1'b1);
		send_request(ACT_ADD, 16'hFFFF, 2'd3, 1'b0, '1, 1'b1);
		send_request(ACT_ADD, 16'd0, 2'd0, 1'b1, '0, 1'b0);
		send_request(ACT_ADD, 16'h5A5A, 2'd1, 1'b1, rand_addr(), 1'b0);
		send_request(ACT_ADD, 16'hA5A5, 2'd2, 1'b0, rand_addr(), 1'b1);
		send_request(ACT_SWITCH, 16'd3, 2'd2, 1'b1, rand_addr(), 1'b0);
		send_request(ACT_SWITCH, 16'd3, 2'd1, 1'b0, rand_addr(), 1'b1);
		// Sleeping a sleeping task is accepted as well.
		send_request(ACT_SLEEP, 16'd3, 2'd0, 1'b1, rand_addr(), 1'b0);
		send_request(ACT_SLEEP, 16'd3, 2'd0, 1'b0, rand_addr(), 1'b1);
		// Sleeping the head rotates the queue.
		send_request(ACT_SLEEP, 16'd2, 2'd3, 1'b1, rand_addr(), 1'b0);
		send_request(ACT_WAKE, 16'd3, 2'd2, 1'b0, rand_addr(), 1'b0);
		send_request(ACT_WAKE, 16'd4, 2'd1, 1'b1, rand_addr(), 1'b1);
		send_request(ACT_WAKE, 16'd4, 2'd0, 1'b0, rand_addr(), 1'b0);
		send_request(ACT_WAKE, 16'd5, 2'd2, 1'b1, rand_addr(), 1'b1);
		send_request(ACT_WAKE, 16'd6, 2'd3, 1'b0, rand_addr(), 1'b0);
		send_request(ACT_SWITCH, 16'd0, 2'd0, 1'b1, rand_addr(), 1'b1);
		drain_results();
	endtask

	task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n)
			send_random_request();
		drain_results();
	endtask

	// The receiver holds off while requests keep coming, so the input must stall.
	task automatic test_backpressure();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		repeat (12)
			send_random_request();
		drain_results();
	endtask

	// Fill the table, overflow it, rotate all the way around a full table, then send random requests.
	task automatic test_table_full();
		sender_idle_pct = 20;
		recv_stall_pct = 20;
		while (tq_count < MAX_TASKS)
			send_request(ACT_ADD, 16'($urandom), 2'($urandom_range(3)),
				1'($urandom_range(1)), rand_addr(), 1'($urandom_range(1)));
		repeat (3)
			send_request(ACT_ADD, 16'($urandom), 2'($urandom_range(3)),
				1'($urandom_range(1)), rand_addr(), 1'($urandom_range(1)));
		repeat (2 * MAX_TASKS)
			send_request(ACT_SWITCH, 16'($urandom), 2'($urandom_range(3)),
				1'($urandom_range(1)), rand_addr(), 1'($urandom_range(1)));
		repeat (40)
			send_random_request();
		drain_results();
	endtask

	// Receiver: a counted hold-off when requested, otherwise random stalls.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each accepted result with the oldest expected one.
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result, current_id", 64'(current_id), '0);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (status !== want.status)
					flag_mismatch("status", 64'(status), 64'(want.status));
				if (assigned_id !== want.assigned)
					flag_mismatch("assigned_id", 64'(assigned_id), 64'(want.assigned));
				if (current_id !== want.cur_id)
					flag_mismatch("current_id", 64'(current_id), 64'(want.cur_id));
				if (current_address !== want.cur_addr)
					flag_mismatch("current_address", current_address, want.cur_addr);
				if (quantum !== want.quantum)
					flag_mismatch("quantum", 64'(quantum), 64'(want.quantum));
			end
			result_count++;
		end
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		reset_queue_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(370, 0, 0);
		test_random_traffic(370, 46, 0);
		test_backpressure();
		test_random_traffic(370, 0, 46);
		test_random_traffic(370, 34, 34);
		test_table_full();
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
